>>> hw/rtl/mm_pkg.sv
// ----------------------------------------------------------------------------
// Matrix multiply package
// Shared widths, command codes, register indexes and the control and status
// bundles that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package mm_pkg;

	localparam int DIM_DEF    = 8;
	localparam int ELEM_W_DEF = 16;
	localparam int IDX_W      = 3;
	localparam int ADDR_W     = 2 * IDX_W;
	localparam int CNT_W      = 4;
	localparam int CNT_RESET  = 8;
	localparam int ACC_W      = 35;
	localparam int CFG_IDX_W  = 2;

	typedef enum logic [1:0] {
		CMD_WR_A,
		CMD_WR_B,
		CMD_RUN
	} cmd_t;

	localparam logic [CFG_IDX_W-1:0] REG_ROWS_A     = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_INNER_SIZE = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_COLS_B     = 2'd2;

	typedef struct packed {
		logic              wr_a;
		logic              wr_b;
		logic              rd_en;
		logic              first_k;
		logic              last_k;
		logic              last_elem;
		logic [ADDR_W-1:0] a_addr;
		logic [ADDR_W-1:0] b_addr;
		logic [IDX_W-1:0]  row;
		logic [IDX_W-1:0]  col;
	} ctl_t;

	typedef struct packed {
		logic elem_done;
	} sts_t;

endpackage

>>> hw/rtl/mm_datapath.sv
// ----------------------------------------------------------------------------
// Matrix multiply datapath
// Element stores for A and B, registered read, multiplier stage,
// accumulator with a pending result, and the output register.
// ----------------------------------------------------------------------------
module mm_datapath import mm_pkg::*; #(
	parameter int DIM        = DIM_DEF,
	parameter int ELEM_WIDTH = ELEM_W_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  ctl_t                         ctl,
	output sts_t                         sts,
	input  logic [IDX_W-1:0]             row_index,
	input  logic [IDX_W-1:0]             col_index,
	input  logic signed [ELEM_WIDTH-1:0] element,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [IDX_W-1:0]             out_row,
	output logic [IDX_W-1:0]             out_col,
	output logic signed [ACC_W-1:0]      product_value,
	output logic                         last_flag
);

	localparam int DEPTH = DIM * DIM;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int PW    = 2 * ELEM_WIDTH;
	localparam int XW    = (PW > ACC_W) ? PW : ACC_W;

	logic [ELEM_WIDTH-1:0] mem_a [DEPTH];
	logic [ELEM_WIDTH-1:0] mem_b [DEPTH];

	logic [ADDR_W-1:0] wr_addr;
	logic              wr_ok;

	logic                         v_s1, first_s1, lastk_s1, lastel_s1;
	logic [IDX_W-1:0]             row_s1, col_s1;
	logic signed [ELEM_WIDTH-1:0] a_s1, b_s1;

	logic                 v_s2, first_s2, lastk_s2, lastel_s2;
	logic [IDX_W-1:0]     row_s2, col_s2;
	logic signed [PW-1:0] prod_s2;

	logic signed [XW-1:0] prod_x;
	logic [ACC_W-1:0]     prod_acc;

	logic [ACC_W-1:0] acc_q;
	logic             res_pend_q;
	logic [IDX_W-1:0] res_row_q, res_col_q;
	logic             res_last_q;

	logic             out_valid_q;
	logic [IDX_W-1:0] out_row_q, out_col_q;
	logic [ACC_W-1:0] out_val_q;
	logic             out_last_q;

	assign wr_addr = ADDR_W'(row_index) * ADDR_W'(DIM) + ADDR_W'(col_index);
	assign wr_ok   = ({1'b0, row_index} < (IDX_W + 1)'(DIM)) &&
	                 ({1'b0, col_index} < (IDX_W + 1)'(DIM));

	always_ff @(posedge clk) begin
		if (ctl.wr_a && wr_ok) begin
			mem_a[wr_addr[AW-1:0]] <= element;
		end
		if (ctl.wr_b && wr_ok) begin
			mem_b[wr_addr[AW-1:0]] <= element;
		end
		if (ctl.rd_en) begin
			a_s1 <= mem_a[ctl.a_addr[AW-1:0]];
			b_s1 <= mem_b[ctl.b_addr[AW-1:0]];
		end
	end

	assign prod_x   = XW'(prod_s2);
	assign prod_acc = prod_x[ACC_W-1:0];

	assign sts.elem_done = res_pend_q && (!out_valid_q || out_ready);

	always_ff @(posedge clk) begin
		first_s1  <= ctl.first_k;
		lastk_s1  <= ctl.last_k;
		lastel_s1 <= ctl.last_elem;
		row_s1    <= ctl.row;
		col_s1    <= ctl.col;
		first_s2  <= first_s1;
		lastk_s2  <= lastk_s1;
		lastel_s2 <= lastel_s1;
		row_s2    <= row_s1;
		col_s2    <= col_s1;
		prod_s2   <= a_s1 * b_s1;
		if (v_s2) begin
			acc_q <= first_s2 ? prod_acc : acc_q + prod_acc;
			if (lastk_s2) begin
				res_row_q  <= row_s2;
				res_col_q  <= col_s2;
				res_last_q <= lastel_s2;
			end
		end
		if (sts.elem_done) begin
			out_row_q  <= res_row_q;
			out_col_q  <= res_col_q;
			out_val_q  <= acc_q;
			out_last_q <= res_last_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			res_pend_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			v_s1 <= ctl.rd_en;
			v_s2 <= v_s1;
			if (sts.elem_done) begin
				res_pend_q <= 1'b0;
			end
			if (v_s2 && lastk_s2) begin
				res_pend_q <= 1'b1;
			end
			if (sts.elem_done) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid     = out_valid_q;
	assign out_row       = out_row_q;
	assign out_col       = out_col_q;
	assign product_value = out_val_q;
	assign last_flag     = out_last_q;

`ifndef ASSERT_OFF
	a_first_no_pending: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s2 && first_s2) |-> !res_pend_q)
		else $error("Accumulator restarted while a result was pending.");

	a_read_no_pending: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.rd_en |-> !res_pend_q)
		else $error("Store read issued while a result was pending.");
`endif

endmodule

>>> hw/rtl/mm_ctrl.sv
// ----------------------------------------------------------------------------
// Matrix multiply controller
// Holds the count registers, accepts items, walks the row, column and inner
// indexes of a run, issuing one store read pair per cycle when not waiting.
// ----------------------------------------------------------------------------
module mm_ctrl import mm_pkg::*; #(
	parameter int DIM = DIM_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CNT_W-1:0]     cfg_data,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [1:0]           cmd,
	output ctl_t                 ctl,
	input  sts_t                 sts
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_ISSUE,
		ST_WAIT
	} state_t;

	state_t           state_q;
	logic [CNT_W-1:0] rows_q, inner_q, cols_q;
	logic [IDX_W-1:0] ilim_q, jlim_q, klim_q;
	logic [IDX_W-1:0] i_q, j_q, k_q;
	ctl_t             rd_q;

	function automatic logic [IDX_W-1:0] last_idx(input logic [CNT_W-1:0] c);
		logic [IDX_W-1:0] r;
		if (c == '0) begin
			r = '0;
		end else if (c > CNT_W'(DIM)) begin
			r = IDX_W'(DIM - 1);
		end else begin
			r = IDX_W'(c - 1'b1);
		end
		return r;
	endfunction

	assign in_ready = (state_q == ST_IDLE);

	always_comb begin
		ctl      = rd_q;
		ctl.wr_a = in_valid && in_ready && (cmd == CMD_WR_A);
		ctl.wr_b = in_valid && in_ready && (cmd == CMD_WR_B);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			rows_q  <= CNT_W'(CNT_RESET);
			inner_q <= CNT_W'(CNT_RESET);
			cols_q  <= CNT_W'(CNT_RESET);
			ilim_q  <= '0;
			jlim_q  <= '0;
			klim_q  <= '0;
			i_q     <= '0;
			j_q     <= '0;
			k_q     <= '0;
			rd_q    <= '0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					REG_ROWS_A: begin
						rows_q <= cfg_data;
					end
					REG_INNER_SIZE: begin
						inner_q <= cfg_data;
					end
					REG_COLS_B: begin
						cols_q <= cfg_data;
					end
					default: begin
					end
				endcase
			end
			rd_q.rd_en <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid && cmd == CMD_RUN) begin
						ilim_q  <= last_idx(rows_q);
						jlim_q  <= last_idx(cols_q);
						klim_q  <= last_idx(inner_q);
						i_q     <= '0;
						j_q     <= '0;
						k_q     <= '0;
						state_q <= ST_ISSUE;
					end
				end
				ST_ISSUE: begin
					rd_q.rd_en     <= 1'b1;
					rd_q.first_k   <= (k_q == '0);
					rd_q.last_k    <= (k_q == klim_q);
					rd_q.last_elem <= (i_q == ilim_q) && (j_q == jlim_q);
					rd_q.row       <= i_q;
					rd_q.col       <= j_q;
					rd_q.a_addr    <= ADDR_W'(i_q) * ADDR_W'(DIM) + ADDR_W'(k_q);
					rd_q.b_addr    <= ADDR_W'(k_q) * ADDR_W'(DIM) + ADDR_W'(j_q);
					if (k_q == klim_q) begin
						k_q     <= '0;
						state_q <= ST_WAIT;
					end else begin
						k_q <= k_q + 1'b1;
					end
				end
				ST_WAIT: begin
					if (sts.elem_done) begin
						if (j_q == jlim_q) begin
							j_q <= '0;
							if (i_q == ilim_q) begin
								state_q <= ST_IDLE;
							end else begin
								i_q     <= i_q + 1'b1;
								state_q <= ST_ISSUE;
							end
						end else begin
							j_q     <= j_q + 1'b1;
							state_q <= ST_ISSUE;
						end
					end
				end
			endcase
		end
	end

`ifndef ASSERT_OFF
	a_no_rd_wr_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(ctl.rd_en && (ctl.wr_a || ctl.wr_b)))
		else $error("Store write collided with a run read.");

	a_k_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		k_q <= klim_q)
		else $error("Inner index ran past its limit.");

	a_done_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		sts.elem_done |-> (state_q == ST_WAIT))
		else $error("Result moved while the controller was not waiting for it.");
`endif

endmodule

>>> hw/rtl/matrix_multiply_top.sv
// ----------------------------------------------------------------------------
// Matrix multiply top level
// Multiplies A (rows_a by inner_size) by B (inner_size by cols_b).
//
// The input channel takes one item per transfer. A write item stores one
// element of A or B; writes stream at one per cycle while in_ready is high.
// A run item emits every element of C in row-major order on the output
// channel, with last_flag set on the final one. Each result element issues
// one store read pair per inner step, then passes the read, multiply and
// accumulate stages before it moves to the output register. in_ready stays
// low from the run transfer until its last result has reached the output
// register. A stalled receiver holds the output register; the next element
// finishes into the accumulator and then waits for the register to free.
// The count registers are written on the configuration port; the user must
// write them only while the block is idle, which the block does not enforce.
// A count of zero acts as one and a count above DIM acts as DIM.
// Reset clears the control state and sets every count to eight; the element
// stores are not cleared and must be written before a run reads them.
// ----------------------------------------------------------------------------
module matrix_multiply_top import mm_pkg::*; #(
	parameter int DIM        = DIM_DEF,
	parameter int ELEM_WIDTH = ELEM_W_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [CFG_IDX_W-1:0]         cfg_index,
	input  logic [CNT_W-1:0]             cfg_data,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [1:0]                   cmd,
	input  logic [IDX_W-1:0]             row_index,
	input  logic [IDX_W-1:0]             col_index,
	input  logic signed [ELEM_WIDTH-1:0] element,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [IDX_W-1:0]             out_row,
	output logic [IDX_W-1:0]             out_col,
	output logic signed [ACC_W-1:0]      product_value,
	output logic                         last_flag
);

	ctl_t ctl;
	sts_t sts;

	mm_ctrl #(
		.DIM(DIM)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.cmd      (cmd),
		.ctl      (ctl),
		.sts      (sts)
	);

	mm_datapath #(
		.DIM       (DIM),
		.ELEM_WIDTH(ELEM_WIDTH)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.ctl          (ctl),
		.sts          (sts),
		.row_index    (row_index),
		.col_index    (col_index),
		.element      (element),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.out_row      (out_row),
		.out_col      (out_col),
		.product_value(product_value),
		.last_flag    (last_flag)
	);

endmodule

>>> tb/sv/matrix_multiply_top_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Matrix multiply testbench
// Loads elements of A and B, sets the three count registers and starts runs.
// Each result element is checked against a behavioral product computed here.
// A short directed table covers the element extremes, every command and the
// zero-count case. Random phases then change the counts, fill the entries
// that each run reads, and run the multiply. Both sides idle at random, one
// stretch has no idling, and one long output stall makes the input back up.
// ----------------------------------------------------------------------------
module matrix_multiply_top_test;
	import mm_pkg::*;

	localparam int                     ITEM_TARGET  = 420;
	localparam int                     LIMIT_CYCLES = 3000000;
	localparam int                     HOLD_CYCLES  = 400;
	localparam int                     SETTLE       = 20;
	localparam int                     N_DIRECTED   = 13;
	localparam logic [1:0]             CMD_SPARE    = 2'd3;
	localparam logic [CFG_IDX_W-1:0]   REG_SPARE    = 2'd3;

	typedef struct packed {
		logic [IDX_W-1:0]        row;
		logic [IDX_W-1:0]        col;
		logic signed [ACC_W-1:0] value;
		logic                    last;
	} product_t;

	typedef struct packed {
		logic [1:0]                   op;
		logic [IDX_W-1:0]             row;
		logic [IDX_W-1:0]             col;
		logic signed [ELEM_W_DEF-1:0] elem;
		bit                           typed;
		logic signed [ACC_W-1:0]      value;
	} step_t;

	logic                         clk           = 1'b0;
	logic                         arst_n        = 1'b0;
	logic                         cfg_we        = 1'b0;
	logic [CFG_IDX_W-1:0]         cfg_index     = '0;
	logic [CNT_W-1:0]             cfg_data      = '0;
	logic                         in_valid      = 1'b0;
	logic                         in_ready;
	logic [1:0]                   cmd           = '0;
	logic [IDX_W-1:0]             row_index     = '0;
	logic [IDX_W-1:0]             col_index     = '0;
	logic signed [ELEM_W_DEF-1:0] element       = '0;
	logic                         out_valid;
	logic                         out_ready     = 1'b0;
	logic [IDX_W-1:0]             out_row;
	logic [IDX_W-1:0]             out_col;
	logic signed [ACC_W-1:0]      product_value;
	logic                         last_flag;

	logic signed [ELEM_W_DEF-1:0] mat_a [DIM_DEF][DIM_DEF];
	logic signed [ELEM_W_DEF-1:0] mat_b [DIM_DEF][DIM_DEF];
	bit                           written_a [DIM_DEF][DIM_DEF];
	bit                           written_b [DIM_DEF][DIM_DEF];
	logic [CNT_W-1:0]             rows_cfg  = CNT_W'(CNT_RESET);
	logic [CNT_W-1:0]             inner_cfg = CNT_W'(CNT_RESET);
	logic [CNT_W-1:0]             cols_cfg  = CNT_W'(CNT_RESET);

	product_t due_products [$];
	int       fail_count   = 0;
	int       sent_items   = 0;
	int       run_count    = 0;
	int       result_count = 0;
	int       setting_count = 0;
	int       cycle_count  = 0;
	int       hold_left    = 0;
	bit       hold_req     = 1'b0;
	bit       steady       = 1'b0;

	step_t directed_steps [N_DIRECTED] = '{
		'{CMD_WR_A,  3'd0, 3'd0, 16'sh8000, 1'b0, 35'sd0},
		'{CMD_WR_B,  3'd0, 3'd0, 16'sh8000, 1'b0, 35'sd0},
		'{CMD_RUN,   3'd7, 3'd7, 16'shffff, 1'b1, 35'sd1073741824},
		'{CMD_WR_B,  3'd0, 3'd0, 16'sh7fff, 1'b0, 35'sd0},
		'{CMD_RUN,   3'd5, 3'd2, 16'sh5555, 1'b1, -35'sd1073709056},
		'{CMD_WR_A,  3'd0, 3'd0, 16'sh7fff, 1'b0, 35'sd0},
		'{CMD_RUN,   3'd2, 3'd5, 16'shaaaa, 1'b1, 35'sd1073676289},
		'{CMD_SPARE, 3'd0, 3'd0, 16'sh0000, 1'b0, 35'sd0},
		'{CMD_RUN,   3'd0, 3'd0, 16'sh0000, 1'b1, 35'sd1073676289},
		'{CMD_WR_A,  3'd7, 3'd7, 16'sh0001, 1'b0, 35'sd0},
		'{CMD_WR_B,  3'd7, 3'd7, 16'shffff, 1'b0, 35'sd0},
		'{CMD_WR_A,  3'd0, 3'd0, 16'sh0000, 1'b0, 35'sd0},
		'{CMD_RUN,   3'd7, 3'd0, 16'sh8000, 1'b1, 35'sd0}
	};

	matrix_multiply_top DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.cmd           (cmd),
		.row_index     (row_index),
		.col_index     (col_index),
		.element       (element),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.out_row       (out_row),
		.out_col       (out_col),
		.product_value (product_value),
		.last_flag     (last_flag)
	);

	always #5 clk = ~clk;

	function automatic int eff_count(input logic [CNT_W-1:0] c);
		if (c == 0)
			return 1;
		if (c > DIM_DEF)
			return DIM_DEF;
		return int'(c);
	endfunction

	function automatic logic signed [ELEM_W_DEF-1:0] pick_element();
		int r;
		r = $urandom_range(99);
		if (r < 12)
			return 16'sh8000;
		if (r < 24)
			return 16'sh7fff;
		if (r < 30)
			return 16'shffff;
		return ELEM_W_DEF'($urandom());
	endfunction

	function automatic logic [CNT_W-1:0] pick_count();
		int r;
		r = $urandom_range(99);
		if (r < 6)
			return '0;
		if (r < 12)
			return CNT_W'($urandom_range(15, 9));
		if (r < 20)
			return CNT_W'(DIM_DEF);
		if (r < 30)
			return CNT_W'(1);
		return CNT_W'($urandom_range(4, 2));
	endfunction

	function automatic void predict_products(input logic [1:0] op, input logic [IDX_W-1:0] r,
			input logic [IDX_W-1:0] c, input logic signed [ELEM_W_DEF-1:0] e);
		longint sum;
		int     ra;
		int     ks;
		int     cb;
		ra = eff_count(rows_cfg);
		ks = eff_count(inner_cfg);
		cb = eff_count(cols_cfg);
		case (op)
			CMD_WR_A: begin
				mat_a[r][c]     = e;
				written_a[r][c] = 1'b1;
			end
			CMD_WR_B: begin
				mat_b[r][c]     = e;
				written_b[r][c] = 1'b1;
			end
			CMD_RUN: begin
				for (int i = 0; i < ra; i++) begin
					for (int j = 0; j < cb; j++) begin
						sum = 0;
						for (int k = 0; k < ks; k++)
							sum += longint'(mat_a[i][k]) * longint'(mat_b[k][j]);
						due_products.push_back('{row: IDX_W'(i), col: IDX_W'(j),
							value: sum[ACC_W-1:0], last: (i == ra - 1 && j == cb - 1)});
					end
				end
			end
			default: begin
			end
		endcase
	endfunction

	task automatic push_item(input logic [1:0] op, input logic [IDX_W-1:0] r,
			input logic [IDX_W-1:0] c, input logic signed [ELEM_W_DEF-1:0] e,
			input bit typed, input logic signed [ACC_W-1:0] value);
		if (!steady && $urandom_range(99) < 17) begin
			in_valid <= 1'b0;
			do
				@(posedge clk);
			while ($urandom_range(99) < 17);
		end
		in_valid  <= 1'b1;
		cmd       <= op;
		row_index <= r;
		col_index <= c;
		element   <= e;
		do
			@(posedge clk);
		while (!in_ready);
		if (typed)
			due_products.push_back('{row: '0, col: '0, value: value, last: 1'b1});
		else
			predict_products(op, r, c, e);
		if (op != CMD_SPARE)
			sent_items++;
		if (op == CMD_RUN)
			run_count++;
	endtask

	task automatic write_counts(input logic [CNT_W-1:0] r, input logic [CNT_W-1:0] k,
			input logic [CNT_W-1:0] c, input bit poke_spare);
		in_valid <= 1'b0;
		while (due_products.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= REG_ROWS_A;
		cfg_data  <= r;
		@(posedge clk);
		cfg_index <= REG_INNER_SIZE;
		cfg_data  <= k;
		@(posedge clk);
		cfg_index <= REG_COLS_B;
		cfg_data  <= c;
		@(posedge clk);
		if (poke_spare) begin
			cfg_index <= REG_SPARE;
			cfg_data  <= 4'd5;
			@(posedge clk);
		end
		cfg_we    <= 1'b0;
		rows_cfg  = r;
		inner_cfg = k;
		cols_cfg  = c;
		setting_count++;
	endtask

	// Writes the entries the next run reads, plus some random ones, then runs.
	task automatic load_and_run(input bit stall_output);
		int ra;
		int ks;
		int cb;
		ra = eff_count(rows_cfg);
		ks = eff_count(inner_cfg);
		cb = eff_count(cols_cfg);
		repeat ($urandom_range(4)) begin
			if ($urandom_range(99) < 10)
				push_item(CMD_SPARE, IDX_W'($urandom()), IDX_W'($urandom()), pick_element(),
					1'b0, '0);
			else
				push_item($urandom_range(1) ? CMD_WR_B : CMD_WR_A, IDX_W'($urandom()),
					IDX_W'($urandom()), pick_element(), 1'b0, '0);
		end
		for (int i = 0; i < ra; i++)
			for (int k = 0; k < ks; k++)
				if (!written_a[i][k] || $urandom_range(99) < 25)
					push_item(CMD_WR_A, IDX_W'(i), IDX_W'(k), pick_element(), 1'b0, '0);
		for (int k = 0; k < ks; k++)
			for (int j = 0; j < cb; j++)
				if (!written_b[k][j] || $urandom_range(99) < 25)
					push_item(CMD_WR_B, IDX_W'(k), IDX_W'(j), pick_element(), 1'b0, '0);
		if (stall_output)
			hold_req = 1'b1;
		push_item(CMD_RUN, IDX_W'($urandom()), IDX_W'($urandom()), pick_element(), 1'b0, '0);
	endtask

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > LIMIT_CYCLES) begin
			$display("matrix_multiply_top_test failed");
			$finish;
		end
	end

	always @(posedge clk) begin : receiver
		product_t want;
		if (out_valid && out_ready) begin
			result_count++;
			if (due_products.size() == 0) begin
				$error("unexpected result at row %0d col %0d", out_row, out_col);
				fail_count++;
			end else begin
				want = due_products.pop_front();
				if (out_row !== want.row) begin
					$error("out_row: expected %0d, got %0d", want.row, out_row);
					fail_count++;
				end
				if (out_col !== want.col) begin
					$error("out_col: expected %0d, got %0d", want.col, out_col);
					fail_count++;
				end
				if (product_value !== want.value) begin
					$error("product_value: expected %0d, got %0d", want.value, product_value);
					fail_count++;
				end
				if (last_flag !== want.last) begin
					$error("last_flag: expected %0d, got %0d", want.last, last_flag);
					fail_count++;
				end
			end
		end
		if (hold_req) begin
			hold_req  = 1'b0;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else begin
			out_ready <= steady || ($urandom_range(99) >= 17);
		end
	end

	initial begin
		int phase;
		phase = 0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// A count of zero acts as one, so the table works on single elements.
		write_counts('0, '0, '0, 1'b1);
		foreach (directed_steps[n])
			push_item(directed_steps[n].op, directed_steps[n].row, directed_steps[n].col,
				directed_steps[n].elem, directed_steps[n].typed, directed_steps[n].value);

		// The output holds off while further items are offered behind a run.
		write_counts(4'd4, 4'd3, 4'd4, 1'b0);
		load_and_run(1'b1);
		load_and_run(1'b0);

		while (sent_items < ITEM_TARGET) begin
			steady = (phase >= 4 && phase < 7);
			if (phase == 10)
				write_counts(4'd15, 4'd15, 4'd15, 1'b0);
			else if (phase == 11)
				write_counts(4'd1, 4'd8, 4'd1, 1'b0);
			else
				write_counts(pick_count(), pick_count(), pick_count(), 1'b0);
			repeat ($urandom_range(3, 1))
				load_and_run(1'b0);
			phase++;
		end
		steady = 1'b0;

		in_valid <= 1'b0;
		while (due_products.size() != 0)
			@(posedge clk);
		repeat (4 * SETTLE) @(posedge clk);
		$display("Sent %0d transfers in %0d runs over %0d count settings.",
			sent_items, run_count, setting_count);
		$display("Checked %0d result elements, %0d mismatches.", result_count, fail_count);
		if (fail_count == 0)
			$display("matrix_multiply_top_test passed");
		else
			$display("matrix_multiply_top_test failed");
		$finish;
	end

endmodule
